>>> design/kwm_pkg.sv
// shared types, constants and codes of the k-way merge unit
package kwm_pkg;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int LIST_W         = 3;
    localparam int STATUS_W       = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_PICK,
        S_LOAD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic push_exec;
        logic scan_clear;
        logic scan_step;
        logic pick;
        logic head_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic refill;
    } t_sts;

endpackage

>>> design/kwm_ram.sv
// generic single-write, single-read ram with registered read data
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/kwm_datapath.sv
// list storage, head registers, pointers, head scan and result registers
module kwm_datapath #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kwm_pkg::t_cmd                       i_cmd,
    output kwm_pkg::t_sts                       o_sts,
    input  logic                                i_op,
    input  logic [kwm_pkg::LIST_W-1:0]          i_list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  i_value,
    output logic signed [kwm_pkg::VALUE_W-1:0]  o_out_value,
    output logic [kwm_pkg::LIST_W-1:0]          o_out_list,
    output logic [kwm_pkg::STATUS_W-1:0]        o_status
);
    import kwm_pkg::*;

    localparam int LW = $clog2(NUM_LISTS);
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(NUM_LISTS * LIST_DEPTH);

    logic                     r_op;
    logic [LW-1:0]            r_idx;
    logic                     r_idx_ok;
    logic [VALUE_W-1:0]       r_value;
    logic [VALUE_W-1:0]       r_head [NUM_LISTS];
    logic [PW-1:0]            r_hptr [NUM_LISTS];
    logic [PW-1:0]            r_tptr [NUM_LISTS];
    logic [CW-1:0]            r_fill [NUM_LISTS];
    logic [NUM_LISTS-1:0]     r_nonempty;
    logic [LW-1:0]            r_sel;
    logic [LW-1:0]            r_best;
    logic                     r_found;
    logic [VALUE_W-1:0]       r_best_val;
    logic [VALUE_W-1:0]       r_res_value;
    logic [LIST_W-1:0]        r_res_list;
    logic [STATUS_W-1:0]      r_res_status;
    logic [VALUE_W-1:0]       r_out_value;
    logic [LIST_W-1:0]        r_out_list;
    logic [STATUS_W-1:0]      r_out_status;

    logic [LW-1:0]            cur;
    logic [CW-1:0]            cur_fill;
    logic [PW-1:0]            cur_h;
    logic [PW-1:0]            cur_t;
    logic [PW-1:0]            h_next;
    logic [PW-1:0]            t_next;
    logic                     push_ok;
    logic                     take;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [VALUE_W-1:0]       ram_rdata;

    assign cur       = (r_op == OP_POP) ? r_best : r_idx;
    assign cur_fill  = r_fill[cur];
    assign cur_h     = r_hptr[cur];
    assign cur_t     = r_tptr[cur];
    assign h_next    = (cur_h == PW'(LIST_DEPTH - 1)) ? '0 : cur_h + PW'(1);
    assign t_next    = (cur_t == PW'(LIST_DEPTH - 1)) ? '0 : cur_t + PW'(1);
    assign push_ok   = r_idx_ok && (cur_fill != CW'(LIST_DEPTH));
    assign ram_we    = i_cmd.push_exec && push_ok;
    assign ram_waddr = AW'(AW'(cur) * AW'(LIST_DEPTH)) + AW'(cur_t);
    assign ram_raddr = AW'(AW'(cur) * AW'(LIST_DEPTH)) + AW'(h_next);

    // ascending scan, so a higher list wins a tie
    assign take = r_nonempty[r_sel] &&
                  (!r_found || ($signed(r_head[r_sel]) <= $signed(r_best_val)));

    assign o_sts.scan_last = (r_sel == LW'(NUM_LISTS - 1));
    assign o_sts.refill    = r_found && (cur_fill > CW'(1));

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_LISTS * LIST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // list bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_hptr[i] <= '0;
                r_tptr[i] <= '0;
                r_fill[i] <= '0;
            end
            r_nonempty <= '0;
            r_found    <= 1'b0;
            r_sel      <= '0;
        end else begin
            if (i_cmd.scan_clear) begin
                r_sel   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_sel <= r_sel + LW'(1);
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (ram_we) begin
                r_tptr[cur]     <= t_next;
                r_fill[cur]     <= cur_fill + CW'(1);
                r_nonempty[cur] <= 1'b1;
            end
            if (i_cmd.pick && r_found) begin
                r_hptr[cur] <= h_next;
                r_fill[cur] <= cur_fill - CW'(1);
                if (cur_fill == CW'(1)) begin
                    r_nonempty[cur] <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_idx    <= LW'(i_list_index);
            r_idx_ok <= (32'(i_list_index) < NUM_LISTS);
            r_value  <= i_value;
        end
        if (i_cmd.scan_step && take) begin
            r_best     <= r_sel;
            r_best_val <= r_head[r_sel];
        end
        if (ram_we && (cur_fill == '0)) begin
            r_head[cur] <= r_value;
        end
        if (i_cmd.head_load) begin
            r_head[cur] <= ram_rdata;
        end
        if (i_cmd.push_exec) begin
            r_res_value  <= '0;
            r_res_list   <= '0;
            r_res_status <= push_ok ? ST_OK : ST_FULL;
        end
        if (i_cmd.pick) begin
            if (r_found) begin
                r_res_value  <= r_best_val;
                r_res_list   <= LIST_W'(r_best);
                r_res_status <= ST_OK;
            end else begin
                r_res_value  <= '0;
                r_res_list   <= '0;
                r_res_status <= ST_EMPTY;
            end
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_list   <= r_res_list;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_value = r_out_value;
    assign o_out_list  = r_out_list;
    assign o_status    = r_out_status;

endmodule

>>> design/kwm_ctrl.sv
// controller state machine of the k-way merge unit
module kwm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    output logic          o_valid,
    input  logic          i_ready,
    output kwm_pkg::t_cmd o_cmd,
    input  kwm_pkg::t_sts i_sts
);
    import kwm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_o_valid;
    logic   n_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_op == OP_PUSH) ? S_PUSH : S_SCAN;
                end
            end
            S_PUSH: n_state = S_FIN;
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = i_sts.refill ? S_LOAD : S_FIN;
            S_LOAD: n_state = S_FIN;
            S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load       = i_valid;
                o_cmd.scan_clear = i_valid;
            end
            S_PUSH: o_cmd.push_exec = 1'b1;
            S_SCAN: o_cmd.scan_step = 1'b1;
            S_PICK: o_cmd.pick      = 1'b1;
            S_LOAD: o_cmd.head_load = 1'b1;
            S_FIN:  o_cmd.out_load  = !r_o_valid || i_ready;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_o_valid = 1'b1;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;

endmodule

>>> design/k_way_sorted_merge_unit.sv
// top level of the k-way sorted merge unit
// Merges NUM_LISTS ascending lists, each a FIFO of LIST_DEPTH signed 32-bit entries in one
// shared RAM. A push item appends i_value to list i_list_index (status 2 if that list is full
// or does not exist); a pop item returns the smallest head over all non-empty lists and
// removes it, the higher list number winning ties, or status 1 when every list is empty.
// One item is worked on at a time. A pop runs the head scan, which compares one list head
// per cycle, then one registered RAM read refills the removed head; that read is skipped
// when the popped list runs empty or every list is empty. The result sits in an output
// register, so the next item is accepted while it waits to be taken, though that item
// finishes only once the waiting one is taken. Every item gives one result item.
module k_way_sorted_merge_unit #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [kwm_pkg::LIST_W-1:0]          i_list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [kwm_pkg::VALUE_W-1:0]  o_out_value,
    output logic [kwm_pkg::LIST_W-1:0]          o_out_list,
    output logic [kwm_pkg::STATUS_W-1:0]        o_status
);
    import kwm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    kwm_datapath #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_list_index (i_list_index),
        .i_value      (i_value),
        .o_out_value  (o_out_value),
        .o_out_list   (o_out_list),
        .o_status     (o_status)
    );

endmodule

>>> tb/sv/tb_k_way_sorted_merge_unit.sv
// self-checking testbench for the k-way sorted merge unit: shadow lists predict every result
module tb_k_way_sorted_merge_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int RUN_ITEMS   = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [LIST_W-1:0]         list;
        logic [STATUS_W-1:0]       status;
    } t_merge_result;

    class t_kway_merge_shadow;
        logic signed [VALUE_W-1:0] shadow_lists [NUM_LISTS_DEF][$];
        t_merge_result             owed_results[$];
        int                        errors;

        function new();
            errors = 0;
        endfunction

        function int list_size(int l);
            return shadow_lists[l].size();
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        function void note_item(logic op, logic [LIST_W-1:0] idx,
                                logic signed [VALUE_W-1:0] val);
            t_merge_result r;
            int            best;
            r    = '0;
            best = -1;
            if (op == OP_PUSH) begin
                if (int'(idx) >= NUM_LISTS_DEF || shadow_lists[idx].size() >= LIST_DEPTH_DEF)
                    r.status = ST_FULL;
                else
                    shadow_lists[idx].push_back(val);
            end else begin
                // ties go to the higher list
                for (int i = 0; i < NUM_LISTS_DEF; i++) begin
                    if (shadow_lists[i].size() != 0 &&
                        (best < 0 || shadow_lists[i][0] <= shadow_lists[best][0]))
                        best = i;
                end
                if (best < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value  = shadow_lists[best].pop_front();
                    r.list   = LIST_W'(best);
                    r.status = ST_OK;
                end
            end
            owed_results.push_back(r);
        endfunction

        function void check_item(logic signed [VALUE_W-1:0] v, logic [LIST_W-1:0] l,
                                 logic [STATUS_W-1:0] s);
            t_merge_result e;
            if (owed_results.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (v !== e.value) begin
                $error("out_value: expected %0d, actual %0d", $signed(e.value), $signed(v));
                errors++;
            end
            if (l !== e.list) begin
                $error("out_list: expected %0d, actual %0d", e.list, l);
                errors++;
            end
            if (s !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, s);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       i_op         = OP_PUSH;
    logic [LIST_W-1:0]          i_list_index = '0;
    logic signed [VALUE_W-1:0]  i_value      = '0;
    logic                       i_ready      = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [VALUE_W-1:0]  o_out_value;
    logic [LIST_W-1:0]          o_out_list;
    logic [STATUS_W-1:0]        o_status;

    t_kway_merge_shadow shadow;
    int               sent      = 0;
    int               cycles    = 0;
    bit               idle_on   = 1'b1;
    longint           tail_val  [NUM_LISTS_DEF];
    bit               tight     [NUM_LISTS_DEF];

    k_way_sorted_merge_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_list_index (i_list_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_value  (o_out_value),
        .o_out_list   (o_out_list),
        .o_status     (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                shadow.check_item(o_out_value, o_out_list, o_status);
            i_ready <= idle_on ? ($urandom_range(0, 99) >= 37) : 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [LIST_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        idle_on = !(sent >= 250 && sent < 350);
        if (idle_on && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_on && $urandom_range(0, 99) < 37) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_list_index <= idx;
        i_value      <= val;
        do @(posedge i_clk); while (!o_ready);
        shadow.note_item(op, idx, val);
        sent++;
    endtask

    task automatic push_item(input int l, input logic signed [VALUE_W-1:0] val);
        send_item(OP_PUSH, LIST_W'(l), val);
    endtask

    task automatic pop_item();
        send_item(OP_POP, LIST_W'($urandom_range(0, 7)), $signed($urandom()));
    endtask

    // next value of an ascending run on list l, restarted when the list runs dry
    function automatic logic signed [VALUE_W-1:0] next_sorted(int l);
        longint nv;
        if (shadow.list_size(l) == 0) begin
            tight[l] = ($urandom_range(0, 1) == 0);
            case ($urandom_range(0, 3))
                0: tail_val[l] = longint'($signed($urandom()));
                1: tail_val[l] = longint'(int'($urandom_range(0, 8))) - 4;
                2: tail_val[l] = -64'sd2147483648 + longint'($urandom_range(0, 3));
                default: tail_val[l] = 64'sd2147483647 - longint'($urandom_range(0, 200));
            endcase
        end
        nv = tail_val[l] + (tight[l] ? longint'($urandom_range(0, 2))
                                     : longint'($urandom_range(0, 1 << 24)));
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        tail_val[l] = nv;
        return nv[VALUE_W-1:0];
    endfunction

    initial begin
        int mode;
        int n;
        int l;
        shadow = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pops, value extremes, ties, unsorted list
        pop_item();
        push_item(0, 32'sh8000_0000);
        push_item(7, 32'sh7fff_ffff);
        push_item(3, 32'sd0);
        push_item(5, -32'sd1);
        push_item(2, 32'sd0);
        push_item(6, 32'sd0);
        repeat (6) pop_item();
        pop_item();
        push_item(1, 32'sd5);
        push_item(1, 32'sd3);
        push_item(4, 32'sd4);
        repeat (3) pop_item();
        push_item(7, 32'sh5555_5555);
        push_item(0, 32'shaaaa_aaaa);
        repeat (2) pop_item();

        while (sent < RUN_ITEMS) begin
            mode = $urandom_range(0, 99);
            if (mode < 8) begin
                // fill one list past its depth
                l = $urandom_range(0, 7);
                n = LIST_DEPTH_DEF + $urandom_range(1, 4);
                repeat (n) push_item(l, next_sorted(l));
            end else if (mode < 50) begin
                n = $urandom_range(8, 20);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 75) begin
                        l = $urandom_range(0, 7);
                        push_item(l, next_sorted(l));
                    end else begin
                        pop_item();
                    end
                end
            end else if (mode < 85) begin
                n = $urandom_range(8, 20);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 80) begin
                        pop_item();
                    end else begin
                        l = $urandom_range(0, 7);
                        push_item(l, next_sorted(l));
                    end
                end
            end else begin
                // unsorted noise
                n = $urandom_range(4, 10);
                repeat (n) send_item(logic'($urandom_range(0, 1)), LIST_W'($urandom_range(0, 7)),
                                     $signed($urandom()));
            end
        end

        i_valid <= 1'b0;
        while (shadow.owed() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
